FILE: hw/rtl/lru_pkg.sv
// shared types, sizes and codes for the per-set lru replacement block
// no dependencies; used by every other file of the block except lru_ram
`default_nettype none

package lru_pkg;

    // geometry
    localparam int NUM_SETS = 64;
    localparam int NUM_WAYS = 8;

    // payload field widths
    localparam int FUNC_W   = 1;
    localparam int SET_W    = 6;
    localparam int WAY_W    = 3;
    localparam int STATUS_W = 2;

    // derived sizes
    localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int POS_W  = $clog2(NUM_WAYS);
    localparam int FILL_W = $clog2(NUM_WAYS + 1);
    localparam int ORDER_W = NUM_WAYS * WAY_W;
    localparam int ROW_W  = FILL_W + ORDER_W;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_VICTIM = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_TOUCH  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VICTIM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } lru_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // latch request beat, launch row read
        logic commit;   // write row back, load response register
    } lru_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic rsp_stall;   // response register full and not taken
    } lru_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_if.sv
// request and response channel interfaces of the lru replacement block
// depends on lru_pkg for field widths
`default_nettype none

interface lru_req_if;
    logic                       valid;
    logic                       ready;
    logic [lru_pkg::FUNC_W-1:0] func;
    logic [lru_pkg::SET_W-1:0]  set_index;
    logic [lru_pkg::WAY_W-1:0]  way;

    modport source (output valid, func, set_index, way, input ready);
    modport sink   (input valid, func, set_index, way, output ready);
endinterface

interface lru_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lru_pkg::STATUS_W-1:0] status;
    logic [lru_pkg::WAY_W-1:0]    victim_way;

    modport source (output valid, status, victim_way, input ready);
    modport sink   (input valid, status, victim_way, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lru_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_ctrl.sv
// controller fsm: sequences accept, row read and write-back of one request
// depends on lru_pkg
`default_nettype none

module lru_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_ready,
    input  wire lru_pkg::lru_sts_t sts,
    output      lru_pkg::lru_cmd_t cmd
);

    lru_pkg::lru_state_t state_reg;
    lru_pkg::lru_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lru_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lru_pkg::ST_LOOKUP;
                end
            end
            lru_pkg::ST_LOOKUP:
            begin
                if (!sts.rsp_stall)
                begin
                    state_next = lru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready  = 1'b0;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            lru_pkg::ST_LOOKUP:
            begin
                cmd.commit = !sts.rsp_stall;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // accept and commit belong to different phases
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.commit))
        else $error("accept and commit in the same cycle");

    // an accepted beat always moves on to the lookup phase
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == lru_pkg::ST_LOOKUP))
        else $error("accept did not enter lookup");

    // lookup holds while the response register is blocked
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lru_pkg::ST_LOOKUP && sts.rsp_stall) |=>
        (state_reg == lru_pkg::ST_LOOKUP))
        else $error("lookup left while response stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/lru_dp.sv
// datapath: order ram, per-set valid bits, move-to-front logic, response register
// depends on lru_pkg and lru_ram
`default_nettype none

module lru_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lru_pkg::lru_cmd_t               cmd,
    output      lru_pkg::lru_sts_t               sts,
    input  wire logic [lru_pkg::FUNC_W-1:0]      req_func,
    input  wire logic [lru_pkg::SET_W-1:0]       req_set_index,
    input  wire logic [lru_pkg::WAY_W-1:0]       req_way,
    output      logic                            rsp_valid,
    input  wire logic                            rsp_ready,
    output      logic [lru_pkg::STATUS_W-1:0]    rsp_status,
    output      logic [lru_pkg::WAY_W-1:0]       rsp_victim_way
);

    localparam int NS = lru_pkg::NUM_SETS;
    localparam int NW = lru_pkg::NUM_WAYS;
    localparam int AW = lru_pkg::SET_AW;
    localparam int PW = lru_pkg::POS_W;
    localparam int FW = lru_pkg::FILL_W;
    localparam int WW = lru_pkg::WAY_W;
    localparam int OW = lru_pkg::ORDER_W;
    localparam int RW = lru_pkg::ROW_W;

    // latched request beat
    logic [lru_pkg::FUNC_W-1:0] func_reg;
    logic [lru_pkg::SET_W-1:0]  set_reg;
    logic [WW-1:0]              way_reg;
    logic                       row_valid_reg;

    // per-set written flags, an unwritten set reads as empty
    logic [NS-1:0]              set_valid_reg;
    logic [NS-1:0]              set_valid_next;

    // response register
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    logic [lru_pkg::STATUS_W-1:0] status_reg;
    logic [WW-1:0]              victim_reg;

    // ram signals
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [RW-1:0]              rd_row;
    logic [RW-1:0]              wr_row;
    logic                       wr_en;

    // row decode and update
    logic [FW-1:0]              fill;
    logic [WW-1:0]              order  [NW];
    logic [WW-1:0]              order_new [NW];
    logic [OW-1:0]              order_flat;
    logic                       hit;
    logic [PW-1:0]              hit_pos;
    logic                       set_ok;
    logic                       way_ok;
    logic                       do_move;
    logic [PW-1:0]              move_pos;
    logic [WW-1:0]              front_way;
    logic [FW-1:0]              fill_new;
    logic [lru_pkg::STATUS_W-1:0] status_new;
    logic [WW-1:0]              victim_new;

    assign rd_addr = AW'(req_set_index);
    assign wr_addr = AW'(set_reg);

    lru_ram #(
        .WIDTH (RW),
        .DEPTH (NS)
    ) u_order_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_row),
        .re    (cmd.accept),
        .raddr (rd_addr),
        .rdata (rd_row)
    );

    // capture request beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= req_func;
            set_reg  <= req_set_index;
            way_reg  <= req_way;
        end
    end

    // row valid flag sampled alongside the ram read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
            set_valid_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                row_valid_reg <= set_valid_reg[rd_addr];
            end
            set_valid_reg <= set_valid_next;
        end
    end

    always_comb
    begin
        set_valid_next = set_valid_reg;
        if (wr_en)
        begin
            set_valid_next[wr_addr] = 1'b1;
        end
    end

    // unpack the row read back from ram
    always_comb
    begin
        fill = row_valid_reg ? rd_row[RW-1 -: FW] : '0;
        for (int i = 0; i < NW; i++)
        begin
            order[i] = rd_row[i*WW +: WW];
        end
    end

    // find the touched way among the valid entries, lowest position wins
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = NW - 1; i >= 0; i--)
        begin
            if ((FW'(i) < fill) && (order[i] == way_reg))
            begin
                hit     = 1'b1;
                hit_pos = PW'(i);
            end
        end
    end

    assign set_ok = (32'(set_reg) < NS);
    assign way_ok = (32'(way_reg) < NW);

    // decide the move and the response
    always_comb
    begin
        do_move    = 1'b0;
        move_pos   = '0;
        front_way  = way_reg;
        fill_new   = fill;
        status_new = lru_pkg::ST_TOUCH;
        victim_new = '0;
        if (func_reg == lru_pkg::FUNC_TOUCH)
        begin
            if (set_ok && way_ok)
            begin
                priority if (hit)
                begin
                    do_move  = 1'b1;
                    move_pos = hit_pos;
                end
                else if (fill < FW'(NW))
                begin
                    // insert at the tail, then bring it to the front
                    do_move  = 1'b1;
                    move_pos = PW'(fill);
                    fill_new = fill + FW'(1);
                end
            end
        end
        else
        begin
            if (!set_ok || fill == '0)
            begin
                status_new = lru_pkg::ST_ERROR;
            end
            else
            begin
                do_move    = 1'b1;
                move_pos   = PW'(fill - FW'(1));
                front_way  = order[PW'(fill - FW'(1))];
                victim_new = front_way;
                status_new = lru_pkg::ST_VICTIM;
            end
        end
    end

    // move-to-front: entries up to the moved position slide back by one
    always_comb
    begin
        for (int j = 0; j < NW; j++)
        begin
            if (j == 0)
            begin
                order_new[j] = front_way;
            end
            else if (PW'(j) <= move_pos)
            begin
                order_new[j] = order[j-1];
            end
            else
            begin
                order_new[j] = order[j];
            end
        end
        for (int j = 0; j < NW; j++)
        begin
            order_flat[j*WW +: WW] = order_new[j];
        end
    end

    assign wr_en  = cmd.commit && do_move;
    assign wr_row = {fill_new, order_flat};

    // response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= status_new;
            victim_reg <= victim_new;
        end
    end

    assign sts.rsp_stall  = rsp_valid_reg && !rsp_ready;
    assign rsp_valid      = rsp_valid_reg;
    assign rsp_status     = status_reg;
    assign rsp_victim_way = victim_reg;

    // every commit leaves a response waiting
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid_reg)
        else $error("commit without response");

    // a set's fill never grows past the way count
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (fill <= FW'(NW)))
        else $error("fill count beyond way count");

    // a written row is marked valid for the next lookup
    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> set_valid_reg[$past(wr_addr)])
        else $error("written set not marked valid");

endmodule

`default_nettype wire

FILE: hw/rtl/lru_replacement_per_set.sv
// top level of the per-set true lru replacement block
// depends on lru_pkg, lru_if, lru_ctrl, lru_dp (and lru_ram through lru_dp)
//
//  channel  dir  beat fields                    handshake
//  req      in   func, set_index, way           valid / ready
//  rsp      out  status, victim_way             valid / ready
//
// each request is accepted with a row read of the set, then completed by
// write-back of the updated row and load of the response register.
// the registered read of the row ram puts the row out in the cycle after accept.
// reset clears the per-set valid flags at once, every set reads empty.
// a full response register that is not taken holds the request in lookup;
// a new request is accepted while the previous response is still waiting.
`default_nettype none

module lru_replacement_per_set (
    input  wire logic clk,
    input  wire logic rst_n,
    lru_req_if.sink   req,
    lru_rsp_if.source rsp
);

    lru_pkg::lru_cmd_t cmd;
    lru_pkg::lru_sts_t sts;
    logic              req_ready;

    lru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lru_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_func       (req.func),
        .req_set_index  (req.set_index),
        .req_way        (req.way),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_victim_way (rsp.victim_way)
    );

    assign req.ready = req_ready;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for lru_replacement_per_set: directed table then random touch and victim beats
// depends on lru_pkg and lru_if; checks each response beat against the table or lru predictor

module tb_top;
    import lru_pkg::*;

    // one expected or observed response beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WAY_W-1:0]    victim_way;
    } rsp_beat_t;

    // one row of the directed table; known marks a hand-typed expectation
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SET_W-1:0]    set_index;
        logic [WAY_W-1:0]    way;
        logic                known;
        logic [STATUS_W-1:0] status;
        logic [WAY_W-1:0]    victim_way;
    } dir_row_t;

    localparam int DIR_ROWS  = 22;
    localparam int RAND_BEATS = 430;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lru_req_if req_if();
    lru_rsp_if rsp_if();

    lru_replacement_per_set dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predicted recency order per set, most recent first, and fill per set
    logic [WAY_W-1:0] way_order [NUM_SETS][NUM_WAYS];
    int unsigned      way_count [NUM_SETS];

    rsp_beat_t pending_rsp [$];
    int        mismatches = 0;
    bit        req_calm   = 1'b0;
    bit        rsp_calm   = 1'b0;

    // directed table: empty-set victims, extremes, full set, re-touch at front
    dir_row_t directed [0:DIR_ROWS-1] = '{
        '{FUNC_VICTIM, 6'd0,  3'd0, 1'b1, ST_ERROR,  3'd0},
        '{FUNC_VICTIM, 6'd63, 3'd7, 1'b1, ST_ERROR,  3'd0},
        '{FUNC_TOUCH,  6'd0,  3'd0, 1'b1, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd0,  3'd0, 1'b1, ST_TOUCH,  3'd0},
        '{FUNC_VICTIM, 6'd0,  3'd7, 1'b1, ST_VICTIM, 3'd0},
        '{FUNC_TOUCH,  6'd63, 3'd7, 1'b1, ST_TOUCH,  3'd0},
        '{FUNC_VICTIM, 6'd63, 3'd5, 1'b1, ST_VICTIM, 3'd7},
        '{FUNC_TOUCH,  6'd1,  3'd0, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd1, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd2, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd3, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd4, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd5, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd6, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd7, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd3, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd3, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_VICTIM, 6'd1,  3'd0, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_VICTIM, 6'd1,  3'd0, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_TOUCH,  6'd1,  3'd0, 1'b0, ST_TOUCH,  3'd0},
        '{FUNC_VICTIM, 6'd2,  3'd0, 1'b1, ST_ERROR,  3'd0},
        '{FUNC_VICTIM, 6'd63, 3'd0, 1'b0, ST_TOUCH,  3'd0}
    };

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // predict one access: update the set's order and return the response
    task automatic lru_access(input logic [FUNC_W-1:0] func, input logic [SET_W-1:0] set_index,
                              input logic [WAY_W-1:0] way, output rsp_beat_t rsp_out);
        int unsigned cnt;
        int unsigned pos;
        logic [WAY_W-1:0] moved;
        cnt = way_count[set_index];
        rsp_out.status     = ST_TOUCH;
        rsp_out.victim_way = '0;
        if (func == FUNC_TOUCH)
        begin
            // find the way, or append it when the set still has room
            pos = cnt;
            for (int i = 0; i < cnt; i++)
            begin
                if (pos == cnt && way_order[set_index][i] == way)
                    pos = i;
            end
            if (pos == cnt)
            begin
                if (cnt >= NUM_WAYS)
                    return;
                way_count[set_index] = cnt + 1;
            end
            moved = way;
        end
        else
        begin
            // empty set gives an error and leaves state alone
            if (cnt == 0)
            begin
                rsp_out.status = ST_ERROR;
                return;
            end
            pos = cnt - 1;
            moved = way_order[set_index][pos];
            rsp_out.status     = ST_VICTIM;
            rsp_out.victim_way = moved;
        end
        // move to front
        for (int i = pos; i > 0; i--)
            way_order[set_index][i] = way_order[set_index][i-1];
        way_order[set_index][0] = moved;
    endtask

    // drive one request beat after a random gap, none when calm; record the expectation on accept
    task automatic send_req(input logic [FUNC_W-1:0] func, input logic [SET_W-1:0] set_index,
                            input logic [WAY_W-1:0] way, input logic known,
                            input rsp_beat_t typed);
        int gap;
        rsp_beat_t want;
        gap = req_calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= func;
        req_if.set_index <= set_index;
        req_if.way       <= way;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        lru_access(func, set_index, way, want);
        if (known)
            want = typed;
        pending_rsp.push_back(want);
    endtask

    // stimulus: reset, directed table, random beats, drain
    initial
    begin
        logic [SET_W-1:0] hot_sets [4];
        logic [SET_W-1:0] pick_set;
        logic [FUNC_W-1:0] pick_func;
        rsp_beat_t typed;
        req_if.valid     = 1'b0;
        req_if.func      = FUNC_TOUCH;
        req_if.set_index = '0;
        req_if.way       = '0;
        foreach (way_count[s])
            way_count[s] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (directed[i])
        begin
            typed.status     = directed[i].status;
            typed.victim_way = directed[i].victim_way;
            send_req(directed[i].func, directed[i].set_index, directed[i].way,
                     directed[i].known, typed);
        end

        // random part: mostly a few hot sets so they fill and evict deeply
        typed = '0;
        for (int n = 0; n < RAND_BEATS; n++)
        begin
            if (n % 100 == 0)
            begin
                foreach (hot_sets[k])
                    hot_sets[k] = SET_W'($urandom_range(0, NUM_SETS - 1));
            end
            if (n % 40 == 0)
                req_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
                pick_set = hot_sets[$urandom_range(0, 3)];
            else
                pick_set = SET_W'($urandom_range(0, NUM_SETS - 1));
            pick_func = ($urandom_range(0, 99) < 55) ? FUNC_TOUCH : FUNC_VICTIM;
            send_req(pick_func, pick_set, WAY_W'($urandom_range(0, NUM_WAYS - 1)), 1'b0,
                     typed);
        end
        req_if.valid <= 1'b0;

        // drain, then wait for any stray beat
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // response side: random stalls, compare each beat with the oldest expectation
    initial
    begin
        int gap;
        int beats;
        rsp_beat_t want;
        beats = 0;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (beats % 40 == 0)
                rsp_calm = ($urandom_range(0, 3) == 0);
            gap = rsp_calm ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid && rsp_if.ready));
            beats++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, status %0d victim_way %0d", $time,
                         rsp_if.status, rsp_if.victim_way);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_if.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_if.status);
                end
                if (rsp_if.victim_way !== want.victim_way)
                begin
                    mismatches++;
                    $display("%0t: victim_way expected %0d actual %0d", $time,
                             want.victim_way, rsp_if.victim_way);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
